// ===== sv/vbmm_pkg.sv =====
package vbmm_pkg;

   // Item field widths
   localparam int CMD_W  = 2;
   localparam int ADDR_W = 14;
   localparam int DATA_W = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR_VERTICAL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_IS_RAM  = 1'd1;

   // Store geometry
   localparam int PATTERN_BANK_BYTES = 4096;
   localparam int NAME_TABLE_BYTES   = 1024;
   localparam int PALETTE_BYTES      = 32;
   localparam int PATTERN_DEPTH      = 2 * PATTERN_BANK_BYTES;
   localparam int NT_DEPTH           = 2 * NAME_TABLE_BYTES;
   localparam int PAT_BANK_AW        = $clog2(PATTERN_BANK_BYTES);
   localparam int PAT_AW             = $clog2(PATTERN_DEPTH);
   localparam int NT_TABLE_AW        = $clog2(NAME_TABLE_BYTES);
   localparam int NT_AW              = $clog2(NT_DEPTH);
   localparam int PAL_AW             = $clog2(PALETTE_BYTES);

   // Address map
   localparam logic [ADDR_W-1:0] NAME_TABLE_BASE = 14'h2000;
   localparam logic [ADDR_W-1:0] NAME_TABLE_LAST = 14'h3EFF;
   localparam int PATTERN_BANK_BIT = 12;   // 0x1000 selects the upper bank

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LOAD  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REGION_PATTERN = 2'd0,
      REGION_NAME    = 2'd1,
      REGION_PALETTE = 2'd2
   } region_type;

   // Decoded access, from the decoder to the top level
   typedef struct packed {
      logic              is_read;
      region_type        region;
      logic              pat_en;
      logic              pat_we;
      logic [PAT_AW-1:0] pat_addr;
      logic              nt_en;
      logic              nt_we;
      logic [NT_AW-1:0]  nt_addr;
      logic              pal_en;
      logic              pal_we;
      logic [PAL_AW-1:0] pal_addr;
   } access_type;

endpackage

// ===== sv/vbmm_req_if.sv =====
interface vbmm_req_if import vbmm_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output cmd, output address, output write_data,
                   input ready);
   modport sink   (input valid, input cmd, input address, input write_data,
                   output ready);
endinterface

// ===== sv/vbmm_rsp_if.sv =====
interface vbmm_rsp_if import vbmm_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

// ===== sv/vbmm_ram.sv =====
module vbmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Single port, registered read; output holds when not enabled
   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem_ff[address] <= write_data;
         end else begin
            read_data_ff <= mem_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/vbmm_decode.sv =====
module vbmm_decode import vbmm_pkg::*; (
   input  logic [CMD_W-1:0]  cmd,
   input  logic [ADDR_W-1:0] address,
   input  logic              mirror_vertical,
   input  logic              pattern_is_ram,
   output access_type        access
);

   logic [1:0]       table_sel;
   logic             nt_half;
   logic [PAL_AW-1:0] pal_raw;
   region_type       region;

   // Region by address range
   always_comb begin
      if (address < NAME_TABLE_BASE) begin
         region = REGION_PATTERN;
      end else if (address <= NAME_TABLE_LAST) begin
         region = REGION_NAME;
      end else begin
         region = REGION_PALETTE;
      end
   end

   // Name table: pick the physical half from the logical table number
   assign table_sel = address[NT_TABLE_AW+1:NT_TABLE_AW];
   assign nt_half   = mirror_vertical ? table_sel[0] : table_sel[1];

   // Palette: backdrop entries of the sprite half alias the background half
   assign pal_raw = address[PAL_AW-1:0];

   always_comb begin
      access          = '0;
      access.region   = region;
      access.pat_addr = {address[PATTERN_BANK_BIT], address[PAT_BANK_AW-1:0]};
      access.nt_addr  = {nt_half, address[NT_TABLE_AW-1:0]};
      access.pal_addr = pal_raw;
      if (pal_raw[PAL_AW-1] && (pal_raw[1:0] == 2'b00)) begin
         access.pal_addr[PAL_AW-1] = 1'b0;
      end

      case (cmd_type'(cmd))
         CMD_READ: begin
            access.is_read = 1'b1;
            access.pat_en  = (region == REGION_PATTERN);
            access.nt_en   = (region == REGION_NAME);
            access.pal_en  = (region == REGION_PALETTE);
         end
         CMD_WRITE: begin
            // pattern writes land only when the store is RAM
            access.pat_en = (region == REGION_PATTERN) && pattern_is_ram;
            access.pat_we = access.pat_en;
            access.nt_en  = (region == REGION_NAME);
            access.nt_we  = access.nt_en;
            access.pal_en = (region == REGION_PALETTE);
            access.pal_we = access.pal_en;
         end
         CMD_LOAD: begin
            access.pat_en = 1'b1;
            access.pat_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/video_bus_memory_map_unit.sv =====
// Video bus memory map. Each item is one access (read, write or pattern load)
// at a 14-bit address: 0x0000-0x1FFF reaches the 8 KiB pattern store (ordinary
// writes land only when pattern_is_ram is set, loads always land), 0x2000-0x3EFF
// reaches 2 KiB of name table RAM through horizontal or vertical mirroring, and
// 0x3F00-0x3FFF reaches the 32-byte palette with its backdrop aliases. Every
// item yields exactly one response: the byte read, or zero for anything else.
// One item is accepted per clock unless a stalled response holds the pipeline,
// which loses no items; an item passes through the registered read of the
// single-port store that the address selects, then the response register. Stores
// power up undefined; read only what has been written. The user must write
// configuration only while no item is in flight; the block does not enforce it.
module video_bus_memory_map_unit import vbmm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   vbmm_req_if.sink               req_chan,
   vbmm_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic mirror_vertical_ff, mirror_vertical_in;
   logic pattern_is_ram_ff, pattern_is_ram_in;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_is_read_ff, s1_is_read_in;
   region_type s1_region_ff, s1_region_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              s1_advance;
   access_type        access;
   logic [DATA_W-1:0] pat_rd, nt_rd, pal_rd;
   logic [DATA_W-1:0] store_rd;

   // Configuration registers
   always_comb begin
      mirror_vertical_in = mirror_vertical_ff;
      pattern_is_ram_in  = pattern_is_ram_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MIRROR_VERTICAL: mirror_vertical_in = csr_write_data[0];
            CSR_PATTERN_IS_RAM:  pattern_is_ram_in  = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_vertical_ff <= 1'b0;
         pattern_is_ram_ff  <= 1'b0;
      end else begin
         mirror_vertical_ff <= mirror_vertical_in;
         pattern_is_ram_ff  <= pattern_is_ram_in;
      end
   end

   // Handshake and flow control
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Address decode
   vbmm_decode u_decode (
      .cmd             (req_chan.cmd),
      .address         (req_chan.address),
      .mirror_vertical (mirror_vertical_ff),
      .pattern_is_ram  (pattern_is_ram_ff),
      .access          (access)
   );

   // Stores, accessed at the accept edge
   vbmm_ram #(.WIDTH(DATA_W), .DEPTH(PATTERN_DEPTH)) u_pattern_ram (
      .clock        (clock),
      .enable       (accept && access.pat_en),
      .write_enable (access.pat_we),
      .address      (access.pat_addr),
      .write_data   (req_chan.write_data),
      .read_data    (pat_rd)
   );

   vbmm_ram #(.WIDTH(DATA_W), .DEPTH(NT_DEPTH)) u_name_table_ram (
      .clock        (clock),
      .enable       (accept && access.nt_en),
      .write_enable (access.nt_we),
      .address      (access.nt_addr),
      .write_data   (req_chan.write_data),
      .read_data    (nt_rd)
   );

   vbmm_ram #(.WIDTH(DATA_W), .DEPTH(PALETTE_BYTES)) u_palette_ram (
      .clock        (clock),
      .enable       (accept && access.pal_en),
      .write_enable (access.pal_we),
      .address      (access.pal_addr),
      .write_data   (req_chan.write_data),
      .read_data    (pal_rd)
   );

   // Stage 1: item waits for its store read
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_is_read_in = s1_is_read_ff;
      s1_region_in  = s1_region_ff;
      if (accept) begin
         s1_valid_in   = 1'b1;
         s1_is_read_in = access.is_read;
         s1_region_in  = access.region;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_is_read_ff <= s1_is_read_in;
      s1_region_ff  <= s1_region_in;
   end

   // Read data select
   always_comb begin
      case (s1_region_ff)
         REGION_PATTERN: store_rd = pat_rd;
         REGION_NAME:    store_rd = nt_rd;
         REGION_PALETTE: store_rd = pal_rd;
         default:        store_rd = '0;
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s1_is_read_ff ? store_rd : '0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

endmodule

// ===== sv/vbmm_checker.sv =====
module vbmm_checker import vbmm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [CMD_W-1:0]  req_cmd,
   input logic [ADDR_W-1:0] req_address,
   input logic [DATA_W-1:0] req_write_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data
);

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // Stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response changed while stalled");

   // A response only rises after an accepted item passes stage 1 and the response register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_accept, 2))
      else $error("response without an accepted item");

   // Non-read items answer zero once stage 1 advances into a drained output
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_cmd != CMD_READ) ##1 (!rsp_valid || rsp_ready)
      |=> rsp_valid && (rsp_read_data == '0))
      else $error("non-read item returned nonzero data");

   // Palette write followed at once by a read of the same address returns it
   a_palette_raw: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_cmd == CMD_WRITE) && (req_address > NAME_TABLE_LAST)
      ##1 req_accept && (req_cmd == CMD_READ) && (req_address == $past(req_address))
          && (!rsp_valid || rsp_ready)
      ##1 rsp_ready
      |=> rsp_valid && (rsp_read_data == $past(req_write_data, 3)))
      else $error("palette read after write mismatch");

endmodule

bind video_bus_memory_map_unit vbmm_checker u_vbmm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_cmd        (req_chan.cmd),
   .req_address    (req_chan.address),
   .req_write_data (req_chan.write_data),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_data  (rsp_chan.read_data)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb import vbmm_pkg::*; ();

   // Run shape
   localparam int RESET_CYCLES    = 9;
   localparam int PHASES          = 5;
   localparam int ITEMS_PER_PHASE = 310;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 600_000;
   localparam int SHOW_LIMIT      = 10;

   // Command code the block treats as a no-op
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Address map pieces used to build accesses
   localparam logic [ADDR_W-1:0] PALETTE_BASE = NAME_TABLE_LAST + 1'b1;
   localparam logic [ADDR_W-1:0] MIRROR_SPAN  = 14'h1000;
   localparam logic [ADDR_W-1:0] ADDR_TOP     = '1;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      bit                typed;
      logic [DATA_W-1:0] want;
   } access_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   vbmm_req_if req_bus ();
   vbmm_rsp_if rsp_bus ();

   video_bus_memory_map_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the three stores and the two settings
   logic [DATA_W-1:0] pattern_mem [PATTERN_DEPTH];
   logic [DATA_W-1:0] name_mem    [NT_DEPTH];
   logic [DATA_W-1:0] palette_mem [PALETTE_BYTES];
   bit pattern_known [PATTERN_DEPTH];
   bit name_known    [NT_DEPTH];
   bit palette_known [PALETTE_BYTES];
   logic [PAT_AW-1:0] pattern_filled[$];
   logic [NT_AW-1:0]  name_filled[$];
   logic [PAL_AW-1:0] palette_filled[$];
   bit mirror_cfg;
   bit pattern_ram_cfg;

   logic [DATA_W-1:0] read_data_due[$];

   // Byte that rides along with a directed item whose result is typed in
   bit                row_typed;
   logic [DATA_W-1:0] row_want;

   bit idling;
   int rsp_hold;
   int cycle_count;
   int failures;
   int checked;
   int n_reads, n_writes, n_loads, n_other;
   int settings_run;
   logic [DATA_W-1:0] predicted;
   logic [DATA_W-1:0] oldest;

   always #1 clock = ~clock;

   // Address decode of each store
   function automatic logic [PAT_AW-1:0] pattern_slot(logic [ADDR_W-1:0] addr);
      return {addr[PATTERN_BANK_BIT], addr[PAT_BANK_AW-1:0]};
   endfunction

   function automatic logic [NT_AW-1:0] name_slot(logic [ADDR_W-1:0] addr);
      logic [1:0] tbl;
      logic       half;
      tbl  = addr[NT_TABLE_AW+1:NT_TABLE_AW];
      half = mirror_cfg ? tbl[0] : tbl[1];
      return {half, addr[NT_TABLE_AW-1:0]};
   endfunction

   function automatic logic [PAL_AW-1:0] palette_slot(logic [ADDR_W-1:0] addr);
      logic [PAL_AW-1:0] i;
      i = addr[PAL_AW-1:0];
      // backdrop entries of the sprite half fold onto the background half
      if (i[PAL_AW-1] && i[1:0] == 2'b00) i[PAL_AW-1] = 1'b0;
      return i;
   endfunction

   function automatic void store_pattern(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] d);
      logic [PAT_AW-1:0] slot;
      slot = pattern_slot(addr);
      pattern_mem[slot] = d;
      if (!pattern_known[slot]) begin
         pattern_known[slot] = 1'b1;
         pattern_filled.push_back(slot);
      end
   endfunction

   // Applies one access to the shadow stores and returns the byte read back
   function automatic logic [DATA_W-1:0] apply_access(logic [CMD_W-1:0] cmd,
                                                      logic [ADDR_W-1:0] addr,
                                                      logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] rd;
      logic [NT_AW-1:0]  nslot;
      logic [PAL_AW-1:0] pslot;
      rd = '0;
      if (cmd == CMD_READ) begin
         if (addr < NAME_TABLE_BASE) rd = pattern_mem[pattern_slot(addr)];
         else if (addr <= NAME_TABLE_LAST) rd = name_mem[name_slot(addr)];
         else rd = palette_mem[palette_slot(addr)];
      end else if (cmd == CMD_WRITE) begin
         if (addr < NAME_TABLE_BASE) begin
            // pattern ROM swallows the write
            if (pattern_ram_cfg) store_pattern(addr, d);
         end else if (addr <= NAME_TABLE_LAST) begin
            nslot = name_slot(addr);
            name_mem[nslot] = d;
            if (!name_known[nslot]) begin
               name_known[nslot] = 1'b1;
               name_filled.push_back(nslot);
            end
         end else begin
            pslot = palette_slot(addr);
            palette_mem[pslot] = d;
            if (!palette_known[pslot]) begin
               palette_known[pslot] = 1'b1;
               palette_filled.push_back(pslot);
            end
         end
      end else if (cmd == CMD_LOAD) begin
         store_pattern(addr, d);
      end
      return rd;
   endfunction

   function automatic access_row_type access_step(logic [CMD_W-1:0] cmd,
                                                  logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] d, bit typed,
                                                  logic [DATA_W-1:0] want);
      access_row_type r;
      r.cmd   = cmd;
      r.addr  = addr;
      r.data  = d;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   // Gap length: mostly none, often short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idling || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random access; reads are steered onto entries that hold data
   task automatic random_access(output access_row_type r);
      int pick;
      int region;
      logic [NT_AW-1:0]  nslot;
      logic [PAL_AW-1:0] pslot;
      logic [1:0]        tbl;
      pick   = $urandom_range(0, 99);
      region = $urandom_range(0, 99);
      r.typed = 1'b0;
      r.want  = '0;
      r.data  = DATA_W'($urandom_range(0, 255));
      if (pick < 40) r.cmd = CMD_READ;
      else if (pick < 75) r.cmd = CMD_WRITE;
      else if (pick < 95) r.cmd = CMD_LOAD;
      else r.cmd = CMD_UNUSED;

      if (r.cmd == CMD_LOAD || r.cmd == CMD_UNUSED)
         r.addr = ADDR_W'($urandom_range(0, ADDR_TOP));
      else if (region < 35)
         r.addr = ADDR_W'($urandom_range(0, NAME_TABLE_BASE - 1));
      else if (region < 75)
         r.addr = ADDR_W'($urandom_range(NAME_TABLE_BASE, NAME_TABLE_LAST));
      else
         r.addr = ADDR_W'($urandom_range(PALETTE_BASE, ADDR_TOP));

      if (r.cmd == CMD_READ) begin
         if (r.addr < NAME_TABLE_BASE) begin
            if (!pattern_known[pattern_slot(r.addr)]) begin
               if (pattern_filled.size() == 0) r.cmd = CMD_LOAD;
               else r.addr = ADDR_W'(pattern_filled[$urandom_range(0,
                                                    pattern_filled.size() - 1)]);
            end
         end else if (r.addr <= NAME_TABLE_LAST) begin
            if (!name_known[name_slot(r.addr)]) begin
               if (name_filled.size() == 0) begin
                  r.cmd = CMD_WRITE;
               end else begin
                  // any logical table that lands on the filled half will do
                  nslot = name_filled[$urandom_range(0, name_filled.size() - 1)];
                  tbl = mirror_cfg ? {1'($urandom_range(0, 1)), nslot[NT_TABLE_AW]}
                                   : {nslot[NT_TABLE_AW], 1'($urandom_range(0, 1))};
                  r.addr = NAME_TABLE_BASE + ADDR_W'({tbl, nslot[NT_TABLE_AW-1:0]});
                  if (tbl != 2'd3 && $urandom_range(0, 1)) r.addr = r.addr + MIRROR_SPAN;
               end
            end
         end else begin
            if (!palette_known[palette_slot(r.addr)]) begin
               if (palette_filled.size() == 0) begin
                  r.cmd = CMD_WRITE;
               end else begin
                  pslot = palette_filled[$urandom_range(0, palette_filled.size() - 1)];
                  r.addr = PALETTE_BASE + ADDR_W'(($urandom_range(0, 7) << PAL_AW) | pslot);
                  if (pslot[PAL_AW-1] == 1'b0 && pslot[1:0] == 2'b00 && $urandom_range(0, 1))
                     r.addr[PAL_AW-1] = 1'b1;
               end
            end
         end
      end
   endtask

   // Drives one item from the falling edge and holds it until accepted
   task automatic send_item(input bit directed, input access_row_type row);
      int gap;
      @(negedge clock);
      if (!directed) random_access(row);
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= row.cmd;
      req_bus.address    <= row.addr;
      req_bus.write_data <= row.data;
      row_typed          <= row.typed;
      row_want           <= row.want;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic end_stream();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (read_data_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_MIRROR_VERTICAL) mirror_cfg = val[0];
      else if (idx == CSR_PATTERN_IS_RAM) pattern_ram_cfg = val[0];
   endtask

   task automatic apply_setting(input bit mirror, input bit pattern_ram);
      write_csr(CSR_MIRROR_VERTICAL, mirror);
      write_csr(CSR_PATTERN_IS_RAM, pattern_ram);
      settings_run++;
   endtask

   // Response channel back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_hold = idle_len();
      end
   end

   // Accepted item: predict its result
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predicted = apply_access(req_bus.cmd, req_bus.address, req_bus.write_data);
         read_data_due.push_back(row_typed ? row_want : predicted);
         if (req_bus.cmd == CMD_READ) n_reads++;
         else if (req_bus.cmd == CMD_WRITE) n_writes++;
         else if (req_bus.cmd == CMD_LOAD) n_loads++;
         else n_other++;
      end
   end

   // Accepted result: compare with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (read_data_due.size() == 0) begin
            failures++;
            if (failures <= SHOW_LIMIT)
               $display("[%0d] read_data %02h arrived with no access pending",
                        cycle_count, rsp_bus.read_data);
         end else begin
            oldest = read_data_due.pop_front();
            checked++;
            if (rsp_bus.read_data !== oldest) begin
               failures++;
               if (failures <= SHOW_LIMIT)
                  $display("[%0d] read_data mismatch: expected %02h, got %02h",
                           cycle_count, oldest, rsp_bus.read_data);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, read_data_due.size());
         $display("video_bus_memory_map_unit verification failed");
         $finish;
      end
   end

   initial begin
      access_row_type directed_rows[$];
      access_row_type blank;
      bit mirror_plan [PHASES];
      bit ram_plan [PHASES];
      mirror_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      ram_plan    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      blank = access_step(CMD_READ, '0, '0, 1'b0, '0);

      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_READ;
      req_bus.address    = '0;
      req_bus.write_data = '0;
      rsp_bus.ready      = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      row_typed          = 1'b0;
      row_want           = '0;
      idling             = 1'b1;
      rsp_hold           = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: horizontal mirroring, pattern store as ROM
      apply_setting(1'b0, 1'b0);
      directed_rows.push_back(access_step(CMD_WRITE, 14'h2000, 8'hA5, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h2000, 8'h00, 1'b1, 8'hA5));
      // table 1 shares a half with table 0
      directed_rows.push_back(access_step(CMD_READ,  14'h2400, 8'h00, 1'b0, 8'h00));
      directed_rows.push_back(access_step(CMD_WRITE, 14'h2BFF, 8'h5A, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h2FFF, 8'h00, 1'b0, 8'h00));
      // 0x3000 window repeats the tables
      directed_rows.push_back(access_step(CMD_READ,  14'h3BFF, 8'h00, 1'b0, 8'h00));
      directed_rows.push_back(access_step(CMD_WRITE, NAME_TABLE_LAST, 8'h42, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h2EFF, 8'h00, 1'b0, 8'h00));
      // palette and its backdrop aliases
      directed_rows.push_back(access_step(CMD_WRITE, PALETTE_BASE, 8'hFF, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h3F10, 8'h00, 1'b0, 8'h00));
      directed_rows.push_back(access_step(CMD_WRITE, 14'h3F1C, 8'h3C, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h3FEC, 8'h00, 1'b0, 8'h00));
      // loads reach the pattern store from anywhere, ROM or not
      directed_rows.push_back(access_step(CMD_LOAD,  14'h0000, 8'h00, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_LOAD,  ADDR_TOP, 8'h81, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h1FFF, 8'h00, 1'b1, 8'h81));
      directed_rows.push_back(access_step(CMD_READ,  14'h0000, 8'h00, 1'b1, 8'h00));
      // ROM write is dropped
      directed_rows.push_back(access_step(CMD_WRITE, 14'h1FFF, 8'h7E, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h1FFF, 8'h00, 1'b1, 8'h81));
      // ROM write must not leak into the palette
      directed_rows.push_back(access_step(CMD_WRITE, 14'h3F1F, 8'h11, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_WRITE, 14'h001F, 8'h99, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h3F1F, 8'h00, 1'b1, 8'h11));
      // unused command: zero back, nothing stored
      directed_rows.push_back(access_step(CMD_UNUSED, PALETTE_BASE, 8'h55, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  PALETTE_BASE, 8'h00, 1'b1, 8'hFF));
      directed_rows.push_back(access_step(CMD_LOAD,  14'h1000, 8'hC3, 1'b1, 8'h00));
      directed_rows.push_back(access_step(CMD_READ,  14'h1000, 8'h00, 1'b1, 8'hC3));
      foreach (directed_rows[i]) send_item(1'b1, directed_rows[i]);
      end_stream();
      wait_drained();

      // Random phases over the setting plan; one phase runs without gaps
      for (int p = 0; p < PHASES; p++) begin
         apply_setting(mirror_plan[p], ram_plan[p]);
         idling = (p != 2);
         repeat (ITEMS_PER_PHASE) send_item(1'b0, blank);
         end_stream();
         wait_drained();
      end

      $display("Covered %0d accesses: %0d reads, %0d writes, %0d loads, %0d no-ops",
               n_reads + n_writes + n_loads + n_other, n_reads, n_writes, n_loads, n_other);
      $display("%0d register settings, %0d results checked, %0d failures",
               settings_run, checked, failures);
      if (failures == 0) begin
         $display("video_bus_memory_map_unit verification clean");
      end else begin
         $display("video_bus_memory_map_unit verification failed");
      end
      $finish;
   end

endmodule

// ===== video_bus_memory_map_unit.f =====
sv/vbmm_pkg.sv
sv/vbmm_req_if.sv
sv/vbmm_rsp_if.sv
sv/vbmm_ram.sv
sv/vbmm_decode.sv
sv/video_bus_memory_map_unit.sv
sv/vbmm_checker.sv
test/tb.sv
